// ===== src/rafa_pkg.sv =====
// ----------------------------------------------------------------------------
// rafa_pkg
// shared types and constants of the first-fit rectangle atlas allocator
// ----------------------------------------------------------------------------
package rafa_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int COORD_BITS  = 13;
	localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
	localparam int DIM_BITS    = 14;
	localparam int TAG_BITS    = 16;
	// wide enough for a sum of two clamped coordinates
	localparam int SUM_BITS    = COORD_BITS + 2;

	localparam logic [1:0] OP_PLACE  = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [2:0] ST_PLACED   = 3'd0;
	localparam logic [2:0] ST_NOROOM   = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_REMOVED  = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	localparam logic [0:0] REG_ATLAS_W = 1'd0;
	localparam logic [0:0] REG_ATLAS_H = 1'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROW,      // start of a row: check y + h fits
		S_CAND,     // start of a candidate: check x + w fits
		S_RD,       // memory read of entry idx in flight
		S_TEST,     // overlap test of entry idx
		S_RM_RD,    // compaction read
		S_RM_WR,    // compaction write
		S_DONE
	} state_t;

endpackage

// ===== src/rafa_table.sv =====
// ----------------------------------------------------------------------------
// rafa_table
// entry table memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module rafa_table (
	input  logic                      clk,
	input  logic                      we,
	input  logic [rafa_pkg::IDX_BITS-1:0]   waddr,
	input  logic [rafa_pkg::COORD_BITS-1:0] wleft,
	input  logic [rafa_pkg::COORD_BITS-1:0] wtop,
	input  logic [rafa_pkg::DIM_BITS-1:0]   wwidth,
	input  logic [rafa_pkg::DIM_BITS-1:0]   wheight,
	input  logic [rafa_pkg::TAG_BITS-1:0]   wtag,
	input  logic [rafa_pkg::IDX_BITS-1:0]   raddr,
	output logic [rafa_pkg::COORD_BITS-1:0] rleft,
	output logic [rafa_pkg::COORD_BITS-1:0] rtop,
	output logic [rafa_pkg::DIM_BITS-1:0]   rwidth,
	output logic [rafa_pkg::DIM_BITS-1:0]   rheight,
	output logic [rafa_pkg::TAG_BITS-1:0]   rtag
);
	import rafa_pkg::*;

	localparam int WBITS = 2 * COORD_BITS + 2 * DIM_BITS + TAG_BITS;

	logic [WBITS-1:0] mem [MAX_ENTRIES];
	logic [WBITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wleft, wtop, wwidth, wheight, wtag};
		end
		rd_q <= mem[raddr];
	end

	assign {rleft, rtop, rwidth, rheight, rtag} = rd_q;

endmodule

// ===== src/rect_atlas_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// rect_atlas_first_fit_allocator
// first-fit rectangle placement in a 2D atlas with an ordered entry table
// ----------------------------------------------------------------------------
// One word is worked on at a time; stall on the input is high from acceptance
// until the result has been taken. A place request walks candidate spots and,
// for each, reads the table entry by entry (S_RD, then S_TEST) through a single
// registered memory port and one shared overlap comparator; each candidate
// opens with S_CAND and each row with S_ROW. A clear and an unused opcode
// present their result in the cycle after acceptance, a table-full answer after
// S_ROW. A remove sweeps the table once, with S_RM_RD and S_RM_WR per entry.
// The table needs no clearing after reset.
module rect_atlas_first_fit_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [13:0] rect_width,
	input  logic [13:0] rect_height,
	input  logic [15:0] entry_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [12:0] pos_x,
	output logic [12:0] pos_y,
	output logic [6:0]  occupancy
);
	import rafa_pkg::*;

	localparam logic [SUM_BITS-1:0] DIM_LIM = SUM_BITS'(1) << COORD_BITS;

	state_t state_q, state_d;

	logic [DIM_BITS-1:0] aw_q, ah_q;
	logic [DIM_BITS-1:0] w_q, h_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [SUM_BITS-1:0] x_q, y_q, ny_q;
	logic [IDX_BITS-1:0] idx_q;
	logic [CNT_BITS-1:0] wr_q;
	logic [CNT_BITS-1:0] cnt_q, rd_cnt_q;
	logic [2:0]          st_q;
	logic [COORD_BITS-1:0] rx_q, ry_q;

	logic                  mem_we;
	logic [IDX_BITS-1:0]   mem_waddr;
	logic [COORD_BITS-1:0] mem_wleft, mem_wtop;
	logic [DIM_BITS-1:0]   mem_wwidth, mem_wheight;
	logic [TAG_BITS-1:0]   mem_wtag;
	logic [COORD_BITS-1:0] e_left, e_top;
	logic [DIM_BITS-1:0]   e_width, e_height;
	logic [TAG_BITS-1:0]   e_tag;

	logic [SUM_BITS-1:0] aw_c, ah_c, w_e, h_e, e_right, e_bottom;
	logic                overlap, row_fits, col_fits, last_ent;

	rafa_table u_table (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wleft  (mem_wleft),
		.wtop   (mem_wtop),
		.wwidth (mem_wwidth),
		.wheight(mem_wheight),
		.wtag   (mem_wtag),
		.raddr  (idx_q),
		.rleft  (e_left),
		.rtop   (e_top),
		.rwidth (e_width),
		.rheight(e_height),
		.rtag   (e_tag)
	);

	// config port
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_ATLAS_W: prdata[DIM_BITS-1:0] = aw_q;
			REG_ATLAS_H: prdata[DIM_BITS-1:0] = ah_q;
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= DIM_BITS'(512);
			ah_q <= DIM_BITS'(512);
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_ATLAS_W) aw_q <= pwdata[DIM_BITS-1:0];
			else                         ah_q <= pwdata[DIM_BITS-1:0];
		end
	end

	// shared comparator datapath
	always_comb begin
		aw_c = (SUM_BITS'(aw_q) > DIM_LIM) ? DIM_LIM : SUM_BITS'(aw_q);
		ah_c = (SUM_BITS'(ah_q) > DIM_LIM) ? DIM_LIM : SUM_BITS'(ah_q);
		w_e  = SUM_BITS'(w_q);
		h_e  = SUM_BITS'(h_q);
		e_right  = SUM_BITS'(e_left) + SUM_BITS'(e_width);
		e_bottom = SUM_BITS'(e_top) + SUM_BITS'(e_height);
		overlap  = (SUM_BITS'(e_left) < x_q + w_e) && (x_q < e_right) &&
		           (SUM_BITS'(e_top) < y_q + h_e) && (y_q < e_bottom);
		row_fits = (y_q + h_e <= ah_c);
		col_fits = (x_q + w_e <= aw_c);
		last_ent = (CNT_BITS'(idx_q) + CNT_BITS'(1) >= cnt_q);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DONE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = (opcode == OP_PLACE) ? S_ROW :
			                                (opcode == OP_REMOVE) ? S_RM_RD : S_DONE;
			S_ROW:   state_d = S_CAND;
			S_CAND:  state_d = S_RD;
			S_RD:    state_d = S_TEST;
			S_TEST:  state_d = S_RD;
			S_RM_RD: state_d = S_RM_WR;
			S_RM_WR: state_d = S_RM_RD;
			S_DONE:  if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		// terminations that depend on data
		case (state_q)
			S_ROW: begin
				if (cnt_q == CNT_BITS'(MAX_ENTRIES) || w_q == '0 || h_q == '0 || !row_fits)
					state_d = S_DONE;
			end
			S_CAND: begin
				if (!col_fits) state_d = (ny_q <= y_q) ? S_DONE : S_ROW;
				else if (cnt_q == '0) state_d = S_DONE;
			end
			S_TEST: begin
				if (overlap) state_d = (e_right <= x_q) ? S_DONE : S_CAND;
				else if (last_ent) state_d = S_DONE;
			end
			S_RM_RD: if (rd_cnt_q >= cnt_q) state_d = S_DONE;
			default: ;
		endcase
	end

	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = wr_q[IDX_BITS-1:0];
		mem_wleft   = e_left;
		mem_wtop    = e_top;
		mem_wwidth  = e_width;
		mem_wheight = e_height;
		mem_wtag    = e_tag;
		if (state_q == S_RM_WR && e_tag != tag_q) begin
			mem_we = 1'b1;
		end else if ((state_q == S_CAND && col_fits && cnt_q == '0) ||
		             (state_q == S_TEST && !overlap && last_ent)) begin
			mem_we      = 1'b1;
			mem_waddr   = cnt_q[IDX_BITS-1:0];
			mem_wleft   = x_q[COORD_BITS-1:0];
			mem_wtop    = y_q[COORD_BITS-1:0];
			mem_wwidth  = w_q;
			mem_wheight = h_q;
			mem_wtag    = tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			rd_cnt_q <= '0;
			idx_q    <= '0;
			wr_q     <= '0;
			st_q     <= ST_NOTFOUND;
			w_q      <= '0;
			h_q      <= '0;
			tag_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			ny_q     <= '0;
			rx_q     <= '0;
			ry_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: if (in_valid) begin
					w_q   <= rect_width;
					h_q   <= rect_height;
					tag_q <= entry_tag;
					x_q   <= '0;
					y_q   <= '0;
					rx_q  <= '0;
					ry_q  <= '0;
					idx_q <= '0;
					wr_q  <= '0;
					rd_cnt_q <= '0;
					if (opcode == OP_CLEAR) begin
						cnt_q <= '0;
						st_q  <= ST_REMOVED;
					end else begin
						st_q  <= (opcode == OP_PLACE) ? ST_NOROOM : ST_NOTFOUND;
					end
				end
				S_ROW: begin
					x_q  <= '0;
					ny_q <= ah_c;
					if (cnt_q == CNT_BITS'(MAX_ENTRIES)) st_q <= ST_FULL;
				end
				S_CAND: begin
					idx_q <= '0;
					if (!col_fits) y_q <= ny_q;
					else if (cnt_q == '0) begin
						st_q  <= ST_PLACED;
						rx_q  <= x_q[COORD_BITS-1:0];
						ry_q  <= y_q[COORD_BITS-1:0];
						cnt_q <= cnt_q + CNT_BITS'(1);
					end
				end
				S_TEST: begin
					if (overlap) begin
						x_q <= e_right;
						if (e_bottom < ny_q) ny_q <= e_bottom;
					end else if (last_ent) begin
						st_q  <= ST_PLACED;
						rx_q  <= x_q[COORD_BITS-1:0];
						ry_q  <= y_q[COORD_BITS-1:0];
						cnt_q <= cnt_q + CNT_BITS'(1);
					end else begin
						idx_q <= idx_q + IDX_BITS'(1);
					end
				end
				// sweep done: the kept entries are packed below wr_q
				S_RM_RD: if (rd_cnt_q >= cnt_q) cnt_q <= wr_q;
				S_RM_WR: begin
					rd_cnt_q <= rd_cnt_q + CNT_BITS'(1);
					idx_q    <= idx_q + IDX_BITS'(1);
					if (e_tag != tag_q) wr_q <= wr_q + CNT_BITS'(1);
					else                st_q <= ST_REMOVED;
				end
				default: ;
			endcase
		end
	end

	assign status    = st_q;
	assign pos_x     = (st_q == ST_PLACED) ? rx_q : '0;
	assign pos_y     = (st_q == ST_PLACED) ? ry_q : '0;
	assign occupancy = cnt_q;

endmodule

// ===== src/rafa_checker.sv =====
// ----------------------------------------------------------------------------
// rafa_checker
// port-level checks of the atlas allocator
// ----------------------------------------------------------------------------
module rafa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [12:0] pos_x,
	input logic [12:0] pos_y,
	input logic [6:0]  occupancy
);
	import rafa_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_PLACED |-> pos_x == '0 && pos_y == '0)
		else $error("position not zero");

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= 7'(MAX_ENTRIES))
		else $error("occupancy out of range");

endmodule

bind rect_atlas_first_fit_allocator rafa_checker u_rafa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.pos_x(pos_x), .pos_y(pos_y), .occupancy(occupancy)
);
